### hw/rtl/pbfn_pkg.sv
package pbfn_pkg;

    localparam int COORD_W   = 16;
    localparam int ACC_W_DEF = 48;
    localparam int OUT_W     = 16;
    localparam int ONE_Q14   = 16384;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int QUO_W     = 16;
    localparam int MAG_W     = 31;
    localparam int NUM_W     = 47;
    localparam int CNT_W     = 5;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic                      is_last;
    } pbfn_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } pbfn_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_EDGE,
        OP_MUL_CLOSE,
        OP_ADD,
        OP_ABS,
        OP_SHIFT,
        OP_SQUARE,
        OP_SQRT,
        OP_DIV,
        OP_EMIT
    } pbfn_op_t;

    typedef struct packed {
        pbfn_op_t   op;
        logic       new_poly;
        logic       first_step;
        logic       last_step;
        logic [1:0] comp;
    } pbfn_cmd_t;

    typedef struct packed {
        logic zero;
        logic big;
        logic in_range;
    } pbfn_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_MUL_CLOSE,
        ST_ADD_CLOSE,
        ST_ABS,
        ST_SHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_EMIT
    } pbfn_state_t;

endpackage

### hw/rtl/pbfn_ctrl.sv
module pbfn_ctrl
    import pbfn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_is_last,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output pbfn_cmd_t  cmd,
    input  pbfn_stat_t stat
);

    pbfn_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       comp_reg, comp_next;
    logic             in_poly_reg, in_poly_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            comp_reg    <= '0;
            in_poly_reg <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            comp_reg    <= comp_next;
            in_poly_reg <= in_poly_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        in_poly_next   = in_poly_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd.op         = OP_NONE;
        cmd.new_poly   = 1'b0;
        cmd.first_step = 1'b0;
        cmd.last_step  = 1'b0;
        cmd.comp       = comp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op       = OP_LOAD;
                    cmd.new_poly = !in_poly_reg;
                    last_next    = s_is_last;
                    in_poly_next = !s_is_last;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.op     = OP_MUL_EDGE;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.op     = OP_ADD;
                state_next = last_reg ? ST_MUL_CLOSE : ST_IDLE;
            end
            ST_MUL_CLOSE: begin
                cmd.op     = OP_MUL_CLOSE;
                state_next = ST_ADD_CLOSE;
            end
            ST_ADD_CLOSE: begin
                cmd.op     = OP_ADD;
                state_next = ST_ABS;
            end
            ST_ABS: begin
                cmd.op     = OP_ABS;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                // Shift one place per cycle until the largest magnitude sits in [2^30, 2^31).
                if (stat.zero) begin
                    state_next = ST_EMIT;
                end else if (stat.in_range) begin
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end else begin
                    cmd.op = OP_SHIFT;
                end
            end
            ST_SQUARE: begin
                cmd.op         = OP_SQUARE;
                cmd.comp       = cnt_reg[1:0];
                cmd.first_step = (cnt_reg == '0);
                cmd.last_step  = (cnt_reg == CNT_W'(3));
                if (cnt_reg == CNT_W'(3)) begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                cmd.op         = OP_SQRT;
                cmd.first_step = (cnt_reg == '0);
                cmd.last_step  = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    cnt_next   = '0;
                    comp_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV: begin
                cmd.op         = OP_DIV;
                cmd.first_step = (cnt_reg == '0);
                cmd.last_step  = (cnt_reg == CNT_W'(DIV_STEPS - 1));
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2) begin
                        state_next = ST_EMIT;
                    end else begin
                        comp_next = comp_reg + 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

### hw/rtl/pbfn_dp.sv
module pbfn_dp
    import pbfn_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_W_DEF
) (
    input  logic       aclk,
    input  pbfn_in_t   s_item,
    input  pbfn_cmd_t  cmd,
    output pbfn_stat_t stat,
    output pbfn_out_t  m_item
);

    localparam int PROD_W = 2 * COORD_W + 2;

    logic signed [COORD_W-1:0]   cur_reg   [3];
    logic signed [COORD_W-1:0]   first_reg [3];
    logic signed [COORD_W-1:0]   prev_reg  [3];
    logic signed [PROD_W-1:0]    prod_reg  [3];
    logic        [ACC_WIDTH-1:0] sum_reg   [3];
    logic        [ACC_WIDTH-1:0] mag_reg   [3];
    logic                        neg_reg   [3];
    logic signed [OUT_W-1:0]     nrm_reg   [3];
    logic        [2*MAG_W-1:0]   sqp_reg;
    logic        [SQ_W-1:0]      sq_reg;
    logic        [SQ_W-1:0]      rad_reg;
    logic        [ROOT_W:0]      srem_reg;
    logic        [ROOT_W-1:0]    root_reg;
    logic        [ROOT_W:0]      drem_reg;
    logic        [QUO_W-1:0]     num_lo_reg;
    logic        [QUO_W-1:0]     quo_reg;
    pbfn_out_t                   out_reg;

    logic signed [COORD_W-1:0] op_p [3];
    logic signed [COORD_W-1:0] op_c [3];
    logic signed [COORD_W:0]   esum [3];
    logic signed [COORD_W:0]   edif [3];
    logic [ACC_WIDTH-1:0]      mag_or;
    logic [ACC_WIDTH-1:0]      mag_sel;

    // Edge operands: previous to current, or current back to first on the closing edge.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            op_p[i] = (cmd.op == OP_MUL_CLOSE) ? cur_reg[i]   : prev_reg[i];
            op_c[i] = (cmd.op == OP_MUL_CLOSE) ? first_reg[i] : cur_reg[i];
            esum[i] = (COORD_W+1)'(op_p[i]) + (COORD_W+1)'(op_c[i]);
            edif[i] = (COORD_W+1)'(op_p[i]) - (COORD_W+1)'(op_c[i]);
        end
    end

    assign mag_or        = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign stat.zero     = (mag_or == '0);
    assign stat.big      = |mag_or[ACC_WIDTH-1:MAG_W];
    assign stat.in_range = !stat.big && mag_or[MAG_W-1];

    always_comb begin
        case (cmd.comp)
            2'd0:    mag_sel = mag_reg[0];
            2'd1:    mag_sel = mag_reg[1];
            default: mag_sel = mag_reg[2];
        endcase
    end

    // Square root step, two radicand bits per cycle.
    logic [ROOT_W:0]   s_rem_in;
    logic [ROOT_W-1:0] s_root_in;
    logic [SQ_W-1:0]   s_rad_in;
    logic [ROOT_W+2:0] s_rem2;
    logic [ROOT_W+2:0] s_trial;
    logic              s_ge;

    always_comb begin
        s_rem_in  = cmd.first_step ? '0 : srem_reg;
        s_root_in = cmd.first_step ? '0 : root_reg;
        s_rad_in  = cmd.first_step ? sq_reg : rad_reg;
        s_rem2    = {s_rem_in, s_rad_in[SQ_W-1 -: 2]};
        s_trial   = {1'b0, s_root_in, 2'b01};
        s_ge      = (s_rem2 >= s_trial);
    end

    // Restoring division, one quotient bit per cycle.
    logic [NUM_W-1:0]  d_num;
    logic [ROOT_W:0]   d_rem_in;
    logic [QUO_W-1:0]  d_lo_in;
    logic [QUO_W-1:0]  d_quo_in;
    logic [ROOT_W+1:0] d_rem2;
    logic [ROOT_W+1:0] d_div;
    logic              d_ge;
    logic [QUO_W-1:0]  d_quo;
    logic [QUO_W-1:0]  d_clamp;

    always_comb begin
        d_num    = {1'b0, mag_sel[MAG_W-1:0], 15'b0} + NUM_W'(root_reg);
        d_rem_in = cmd.first_step ? (ROOT_W+1)'(d_num[NUM_W-1:QUO_W]) : drem_reg;
        d_lo_in  = cmd.first_step ? d_num[QUO_W-1:0] : num_lo_reg;
        d_quo_in = cmd.first_step ? '0 : quo_reg;
        d_rem2   = {d_rem_in, d_lo_in[QUO_W-1]};
        d_div    = {1'b0, root_reg, 1'b0};
        d_ge     = (d_rem2 >= d_div);
        d_quo    = {d_quo_in[QUO_W-2:0], d_ge};
        d_clamp  = (d_quo > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : d_quo;
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                cur_reg[0] <= s_item.vert_x;
                cur_reg[1] <= s_item.vert_y;
                cur_reg[2] <= s_item.vert_z;
                if (cmd.new_poly) begin
                    first_reg[0] <= s_item.vert_x;
                    first_reg[1] <= s_item.vert_y;
                    first_reg[2] <= s_item.vert_z;
                    prev_reg[0]  <= s_item.vert_x;
                    prev_reg[1]  <= s_item.vert_y;
                    prev_reg[2]  <= s_item.vert_z;
                    for (int i = 0; i < 3; i++) begin
                        sum_reg[i] <= '0;
                    end
                end
            end
            OP_MUL_EDGE, OP_MUL_CLOSE: begin
                prod_reg[0] <= esum[2] * edif[1];
                prod_reg[1] <= esum[0] * edif[2];
                prod_reg[2] <= esum[1] * edif[0];
            end
            OP_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    sum_reg[i]  <= sum_reg[i]
                                   + {{(ACC_WIDTH-PROD_W){prod_reg[i][PROD_W-1]}}, prod_reg[i]};
                    prev_reg[i] <= cur_reg[i];
                end
            end
            OP_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= sum_reg[i][ACC_WIDTH-1];
                    mag_reg[i] <= sum_reg[i][ACC_WIDTH-1] ? ('0 - sum_reg[i]) : sum_reg[i];
                end
            end
            OP_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= stat.big ? (mag_reg[i] >> 1) : (mag_reg[i] << 1);
                end
            end
            OP_SQUARE: begin
                if (!cmd.last_step) begin
                    sqp_reg <= mag_sel[MAG_W-1:0] * mag_sel[MAG_W-1:0];
                end
                sq_reg <= cmd.first_step ? '0 : (sq_reg + SQ_W'(sqp_reg));
            end
            OP_SQRT: begin
                rad_reg  <= {s_rad_in[SQ_W-3:0], 2'b00};
                srem_reg <= s_ge ? (ROOT_W+1)'(s_rem2 - s_trial) : (ROOT_W+1)'(s_rem2);
                root_reg <= {s_root_in[ROOT_W-2:0], s_ge};
            end
            OP_DIV: begin
                drem_reg   <= d_ge ? (ROOT_W+1)'(d_rem2 - d_div) : (ROOT_W+1)'(d_rem2);
                num_lo_reg <= {d_lo_in[QUO_W-2:0], 1'b0};
                quo_reg    <= d_quo;
                if (cmd.last_step) begin
                    nrm_reg[cmd.comp] <= neg_reg[cmd.comp] ? ('0 - d_clamp) : d_clamp;
                end
            end
            OP_EMIT: begin
                out_reg.normal_x   <= stat.zero ? '0 : nrm_reg[0];
                out_reg.normal_y   <= stat.zero ? '0 : nrm_reg[1];
                out_reg.normal_z   <= stat.zero ? '0 : nrm_reg[2];
                out_reg.degenerate <= stat.zero;
            end
            default: ;
        endcase
    end

    assign m_item = out_reg;

endmodule

### hw/rtl/polygon_best_fit_normal.sv
// Polygon normal by Newell's method.
// Vertices arrive on the s_ channel (valid/ready), one transaction per vertex, as signed
// Q8.8 coordinates; is_last marks the final vertex of a polygon. The first vertex after
// reset or after a final vertex starts a new polygon.
// Each vertex that is not the last passes through capture, edge products and accumulate
// in that order, and the next vertex is taken only once accumulate is done.
// The final vertex also closes the polygon and normalises the sum: the closing edge
// products and accumulate, the magnitudes, a shift of one bit place per step until the
// largest magnitude is in range, the squares, the bit-serial square root, three 16-step
// divisions and the load of the result register, which waits for a free result
// register. One m_ transaction carries the Q1.14 unit normal and the degenerate flag.
// A polygon whose sums are all zero skips the squares, root and divisions and reports a
// zero vector with degenerate set.
// Reset (aresetn low, synchronous) clears the controller and drops m_valid.
// While the receiver holds m_ready low the result waits in its register; the block keeps
// accepting vertices and stalls only when a new result is ready to be written.
module polygon_best_fit_normal
    import pbfn_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_W_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pbfn_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output pbfn_out_t m_item
);

    pbfn_cmd_t  cmd;
    pbfn_stat_t stat;

    pbfn_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_item.is_last),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pbfn_dp #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .aclk   (aclk),
        .s_item (s_item),
        .cmd    (cmd),
        .stat   (stat),
        .m_item (m_item)
    );

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.degenerate |->
            m_item.normal_x == '0 && m_item.normal_y == '0 && m_item.normal_z == '0)
        else $error("degenerate result carries a non-zero normal");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_item.normal_x <= 16'sd16384 && m_item.normal_x >= -16'sd16384 &&
            m_item.normal_y <= 16'sd16384 && m_item.normal_y >= -16'sd16384 &&
            m_item.normal_z <= 16'sd16384 && m_item.normal_z >= -16'sd16384)
        else $error("normal component outside unit range");

    a_result_needs_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready || !$past(s_ready))
        else $error("result appeared without a vertex in flight");

endmodule

### test/tb_polygon_best_fit_normal.sv
`timescale 1ns / 100ps

module tb_polygon_best_fit_normal;
    import pbfn_pkg::*;

    localparam int ACC_W = 48;
    localparam int N_RANDOM = 1950;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    pbfn_in_t  s_item;
    logic      m_valid;
    logic      m_ready;
    pbfn_out_t m_item;

    polygon_best_fit_normal #(.ACC_WIDTH(ACC_W)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Predicted polygon state.
    logic signed [63:0] first_v [3];
    logic signed [63:0] prev_v [3];
    logic [ACC_W-1:0]   acc [3];
    logic               open_poly;

    pbfn_out_t normal_queue[$];
    int        fail_count;
    bit        quiet_tail;
    bit        hold_sender;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("polygon_best_fit_normal verification failed");
        $finish;
    end

    function automatic logic [ACC_W-1:0] edge_term(logic signed [63:0] sa,
                                                   logic signed [63:0] sb,
                                                   logic signed [63:0] da,
                                                   logic signed [63:0] db);
        logic signed [63:0] prod;
        begin
            prod = (sa + sb) * (da - db);
            return prod[ACC_W-1:0];
        end
    endfunction

    task automatic add_newell(logic signed [63:0] p [3], logic signed [63:0] c [3]);
        acc[0] = acc[0] + edge_term(p[2], c[2], p[1], c[1]);
        acc[1] = acc[1] + edge_term(p[0], c[0], p[2], c[2]);
        acc[2] = acc[2] + edge_term(p[1], c[1], p[0], c[0]);
    endtask

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        end
    endfunction

    function automatic pbfn_out_t unit_normal();
        logic [63:0] mag [3];
        logic        neg [3];
        logic [63:0] top;
        logic [63:0] root;
        logic [63:0] q;
        logic [15:0] comp [3];
        int          width;
        pbfn_out_t   r;
        begin
            top = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = acc[i][ACC_W-1];
                mag[i] = neg[i] ? 64'(ACC_W'(-acc[i])) : 64'(acc[i]);
                if (mag[i] > top) top = mag[i];
            end
            if (top == 0) begin
                r = '0;
                r.degenerate = 1'b1;
                return r;
            end
            width = 0;
            while (width < 64 && (top >> width) != 0) width++;
            for (int i = 0; i < 3; i++) begin
                if (width > 31) mag[i] = mag[i] >> (width - 31);
                else mag[i] = mag[i] << (31 - width);
            end
            root = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
            for (int i = 0; i < 3; i++) begin
                q = (2 * ONE_Q14 * mag[i] + root) / (2 * root);
                if (q > ONE_Q14) q = ONE_Q14;
                comp[i] = neg[i] ? 16'(-q) : 16'(q);
            end
            r.normal_x = comp[0];
            r.normal_y = comp[1];
            r.normal_z = comp[2];
            r.degenerate = 1'b0;
            return r;
        end
    endfunction

    task automatic predict_vertex(pbfn_in_t v);
        logic signed [63:0] cur [3];
        begin
            cur[0] = 64'(v.vert_x);
            cur[1] = 64'(v.vert_y);
            cur[2] = 64'(v.vert_z);
            if (!open_poly) begin
                first_v = cur;
                prev_v = cur;
                acc[0] = '0; acc[1] = '0; acc[2] = '0;
            end
            add_newell(prev_v, cur);
            prev_v = cur;
            if (!v.is_last) begin
                open_poly = 1'b1;
            end else begin
                add_newell(cur, first_v);
                normal_queue.push_back(unit_normal());
                open_poly = 1'b0;
            end
        end
    endtask

    // Result side: random back-pressure and comparison at the rising edge.
    always @(posedge aclk) begin
        pbfn_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (normal_queue.size() == 0) begin
                $error("unexpected result transaction %h", m_item);
                fail_count++;
            end else begin
                want = normal_queue.pop_front();
                if (m_item.normal_x !== want.normal_x) begin
                    $error("normal_x expected %0d actual %0d", want.normal_x, m_item.normal_x);
                    fail_count++;
                end
                if (m_item.normal_y !== want.normal_y) begin
                    $error("normal_y expected %0d actual %0d", want.normal_y, m_item.normal_y);
                    fail_count++;
                end
                if (m_item.normal_z !== want.normal_z) begin
                    $error("normal_z expected %0d actual %0d", want.normal_z, m_item.normal_z);
                    fail_count++;
                end
                if (m_item.degenerate !== want.degenerate) begin
                    $error("degenerate expected %0d actual %0d",
                           want.degenerate, m_item.degenerate);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sends one vertex; valid stays high until the transaction is accepted, and the
    // next vertex follows at the falling edge after acceptance unless an idle burst comes.
    task automatic send_vertex(pbfn_in_t v, bit checked, pbfn_out_t typed);
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_item  <= v;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_vertex(v);
        if (checked && v.is_last && normal_queue[$] !== typed) begin
            $error("typed expectation %h differs from prediction %h",
                   typed, normal_queue[$]);
            fail_count++;
        end
        @(negedge aclk);
    endtask

    function automatic pbfn_in_t vtx(int x, int y, int z, bit last);
        pbfn_in_t v;
        v.vert_x = 16'(x);
        v.vert_y = 16'(y);
        v.vert_z = 16'(z);
        v.is_last = last;
        return v;
    endfunction

    function automatic pbfn_out_t nrm(int x, int y, int z, bit degen);
        pbfn_out_t r;
        r.normal_x = 16'(x);
        r.normal_y = 16'(y);
        r.normal_z = 16'(z);
        r.degenerate = degen;
        return r;
    endfunction

    typedef struct {
        pbfn_in_t  v;
        bit        checked;
        pbfn_out_t typed;
    } stim_row_t;

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 2047) - 1024;
            default: return ($urandom_range(0, 1) ? 32767 : -32768);
        endcase
    endfunction

    initial begin
        stim_row_t rows[$];
        int n_sent;
        int nverts;
        int mode;

        fail_count = 0;
        quiet_tail = 0;
        hold_sender = 0;
        open_poly = 0;
        acc[0] = '0; acc[1] = '0; acc[2] = '0;
        for (int i = 0; i < 3; i++) begin
            first_v[i] = 0;
            prev_v[i] = 0;
        end
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Single vertex polygon right after reset, then a zero-area one.
        rows.push_back('{vtx(5, 6, 7, 1), 1, nrm(0, 0, 0, 1)});
        rows.push_back('{vtx(0, 0, 0, 0), 0, '0});
        rows.push_back('{vtx(0, 0, 0, 1), 1, nrm(0, 0, 0, 1)});
        // Unit triangle in the xy plane, counter-clockwise, gives +z.
        rows.push_back('{vtx(0, 0, 0, 0), 0, '0});
        rows.push_back('{vtx(256, 0, 0, 0), 0, '0});
        rows.push_back('{vtx(0, 256, 0, 1), 1, nrm(0, 0, 16384, 0)});
        // Clockwise triangle in the yz plane gives -x.
        rows.push_back('{vtx(0, 0, 0, 0), 0, '0});
        rows.push_back('{vtx(0, 0, 256, 0), 0, '0});
        rows.push_back('{vtx(0, 256, 0, 1), 1, nrm(-16384, 0, 0, 0)});
        // Extreme coordinates at both ends of the signed range.
        rows.push_back('{vtx(-32768, -32768, -32768, 0), 0, '0});
        rows.push_back('{vtx(32767, -32768, 32767, 0), 0, '0});
        rows.push_back('{vtx(32767, 32767, -32768, 0), 0, '0});
        rows.push_back('{vtx(-32768, 32767, 32767, 1), 0, '0});
        rows.push_back('{vtx(32767, 32767, 32767, 0), 0, '0});
        rows.push_back('{vtx(-32768, 0, 32767, 0), 0, '0});
        rows.push_back('{vtx(0, -32768, -1, 1), 0, '0});
        // Collinear points are degenerate.
        rows.push_back('{vtx(1, 1, 1, 0), 0, '0});
        rows.push_back('{vtx(2, 2, 2, 0), 0, '0});
        rows.push_back('{vtx(3, 3, 3, 1), 1, nrm(0, 0, 0, 1)});
        // Tilted quad.
        rows.push_back('{vtx(-100, 50, 3, 0), 0, '0});
        rows.push_back('{vtx(200, -70, 9, 0), 0, '0});
        rows.push_back('{vtx(180, 300, -40, 0), 0, '0});
        rows.push_back('{vtx(-90, 250, 77, 1), 0, '0});

        foreach (rows[i]) send_vertex(rows[i].v, rows[i].checked, rows[i].typed);

        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            if (n_sent > N_RANDOM - 150) quiet_tail = 1;
            // Once, the sender waits until the block has drained.
            if (!hold_sender && n_sent > N_RANDOM / 2) begin
                hold_sender = 1;
                s_valid <= 1'b0;
                @(negedge aclk);
                while (normal_queue.size() != 0) @(negedge aclk);
            end
            mode = $urandom_range(0, 5);
            nverts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 8);
            for (int k = 0; k < nverts; k++) begin
                send_vertex(vtx(rand_coord(mode < 3 ? 0 : (mode < 5 ? 1 : 2)),
                                rand_coord(mode < 3 ? 0 : (mode < 5 ? 1 : 2)),
                                (mode == 4) ? 0 : rand_coord(mode < 3 ? 0 : 1),
                                k == nverts - 1), 0, '0);
                n_sent++;
            end
        end
        s_valid <= 1'b0;

        while (normal_queue.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0 && normal_queue.size() == 0) begin
            $display("polygon_best_fit_normal verification clean");
        end else begin
            $display("polygon_best_fit_normal verification failed");
        end
        $finish;
    end

endmodule

### polygon_best_fit_normal.f
hw/rtl/pbfn_pkg.sv
hw/rtl/pbfn_ctrl.sv
hw/rtl/pbfn_dp.sv
hw/rtl/polygon_best_fit_normal.sv
test/tb_polygon_best_fit_normal.sv
